// File: sv/blm_pkg.sv
// Shared types, widths and constants of the battery level monitor.
package blm_pkg;

    localparam int AVG_DEPTH  = 8;
    localparam int ADC_W      = 12;
    localparam int SCALE_W    = 20;
    localparam int PROD_W     = ADC_W + SCALE_W;
    localparam int MV_W       = 16;
    localparam int SLOT_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int CNT_W      = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W      = MV_W + $clog2(AVG_DEPTH);
    localparam int PCT_W      = 7;
    localparam int PCT_NUM_W  = MV_W + PCT_W;
    localparam int DIV_W      = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
    localparam int DIVISOR_W  = MV_W;
    localparam int STEP_W     = $clog2(DIV_W + 1);
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

    // level_state codes
    localparam logic [2:0] LVL_CHARGING = 3'd0;
    localparam logic [2:0] LVL_FULL     = 3'd1;
    localparam logic [2:0] LVL_GOOD     = 3'd2;
    localparam logic [2:0] LVL_LOW      = 3'd3;
    localparam logic [2:0] LVL_EMPTY    = 3'd4;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SCALE   = 3'd0;
    localparam logic [2:0] REG_FULL    = 3'd1;
    localparam logic [2:0] REG_MID     = 3'd2;
    localparam logic [2:0] REG_LOW     = 3'd3;
    localparam logic [2:0] REG_EMPTY   = 3'd4;
    localparam logic [2:0] REG_CHARGED = 3'd5;

    localparam logic [SCALE_W-1:0] SCALE_RST   = 20'd105631;
    localparam logic [MV_W-1:0]    FULL_RST    = 16'd4200;
    localparam logic [MV_W-1:0]    MID_RST     = 16'd3700;
    localparam logic [MV_W-1:0]    LOW_RST     = 16'd3500;
    localparam logic [MV_W-1:0]    EMPTY_RST   = 16'd3300;
    localparam logic [MV_W-1:0]    CHARGED_RST = 16'd4100;

    typedef struct packed {
        logic [ADC_W-1:0] adc_code;
        logic             charging_pin;
    } in_word_t;

    typedef struct packed {
        logic [MV_W-1:0]  avg_mv;
        logic [2:0]       level_state;
        logic [PCT_W-1:0] percent;
        logic             fully_charged;
    } out_word_t;

    typedef struct packed {
        logic [SCALE_W-1:0] scale_q16;
        logic [MV_W-1:0]    full_mv;
        logic [MV_W-1:0]    mid_mv;
        logic [MV_W-1:0]    low_mv;
        logic [MV_W-1:0]    empty_mv;
        logic [MV_W-1:0]    charged_mv;
    } cfg_t;

    // one scaled sample handed from front to back
    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            charging;
    } q_word_t;

    typedef struct packed {
        logic                 start;
        logic [STEP_W-1:0]    steps;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_AVG_WAIT,
        ST_PCT,
        ST_PCT_WAIT,
        ST_FINISH
    } back_state_t;

endpackage

// File: sv/blm_front.sv
// Front end: accepts input words and scales the ADC code to millivolts.
module blm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  blm_pkg::in_word_t in_word,
    input  logic [blm_pkg::SCALE_W-1:0] scale_q16,
    output logic              push,
    output blm_pkg::q_word_t  push_word,
    input  logic              q_full
);

    logic                       valid_reg, valid_next;
    logic [blm_pkg::PROD_W-1:0] prod_reg;
    logic                       chg_reg;
    logic                       accept;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;

    assign push_word.mv       = prod_reg[blm_pkg::PROD_W-1 -: blm_pkg::MV_W];
    assign push_word.charging = chg_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= blm_pkg::PROD_W'(in_word.adc_code) * blm_pkg::PROD_W'(scale_q16);
            chg_reg  <= in_word.charging_pin;
        end
    end

endmodule

// File: sv/blm_queue.sv
// Two-entry queue between front and back.
module blm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  blm_pkg::q_word_t push_word,
    input  logic             pop,
    output blm_pkg::q_word_t pop_word,
    output logic             empty,
    output logic             full
);

    blm_pkg::q_word_t slots_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_word = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: sv/blm_div.sv
// Restoring divider, one quotient bit per cycle, shared by average and percent.
module blm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  blm_pkg::div_req_t req,
    output blm_pkg::div_rsp_t rsp
);

    logic [blm_pkg::DIV_W-1:0]     q_reg;
    logic [blm_pkg::DIVISOR_W-1:0] rem_reg;
    logic [blm_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [blm_pkg::STEP_W-1:0]    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [blm_pkg::DIVISOR_W:0]   shifted;
    logic [blm_pkg::DIVISOR_W:0]   diff;
    logic                          ge;

    assign shifted = {rem_reg, q_reg[blm_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign ge      = (shifted >= {1'b0, divisor_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == blm_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg       <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[blm_pkg::DIV_W-2:0], ge};
            rem_reg <= ge ? diff[blm_pkg::DIVISOR_W-1:0] : shifted[blm_pkg::DIVISOR_W-1:0];
        end
    end

endmodule

// File: sv/blm_back.sv
// Back end: sample ring, running sum, average, percentage, classification and output register.
module blm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  blm_pkg::cfg_t     cfg,
    input  logic              q_empty,
    input  blm_pkg::q_word_t  q_word,
    output logic              pop,
    output blm_pkg::div_req_t div_req,
    input  blm_pkg::div_rsp_t div_rsp,
    output logic              out_valid,
    input  logic              out_stall,
    output blm_pkg::out_word_t out_word
);

    blm_pkg::back_state_t state_reg, state_next;

    logic [blm_pkg::MV_W-1:0]   ring_reg [blm_pkg::AVG_DEPTH];
    logic [blm_pkg::SUM_W-1:0]  sum_reg;
    logic [blm_pkg::CNT_W-1:0]  fill_reg;
    logic [blm_pkg::SLOT_W-1:0] slot_reg;
    logic                       chg_reg;
    logic [blm_pkg::MV_W-1:0]   avg_reg;
    logic [blm_pkg::PCT_W-1:0]  pct_reg;
    logic                       out_valid_reg, out_valid_next;
    blm_pkg::out_word_t         out_word_reg;

    logic                       load_out;
    logic                       pct_direct;
    logic [blm_pkg::PCT_W-1:0]  pct_direct_val;
    logic [blm_pkg::MV_W-1:0]   pct_delta;
    logic [2:0]                 level;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign pct_delta = avg_reg - cfg.empty_mv;

    // clamped and degenerate-span cases settle without a division
    always_comb
    begin
        pct_direct     = 1'b1;
        pct_direct_val = blm_pkg::PCT_ZERO;
        if (cfg.full_mv <= cfg.empty_mv)
        begin
            pct_direct_val = (avg_reg >= cfg.full_mv) ? blm_pkg::PCT_FULL : blm_pkg::PCT_ZERO;
        end
        else if (avg_reg <= cfg.empty_mv)
        begin
            pct_direct_val = blm_pkg::PCT_ZERO;
        end
        else if (avg_reg >= cfg.full_mv)
        begin
            pct_direct_val = blm_pkg::PCT_FULL;
        end
        else
        begin
            pct_direct = 1'b0;
        end
    end

    always_comb
    begin
        if (chg_reg)
        begin
            level = blm_pkg::LVL_CHARGING;
        end
        else if (avg_reg >= cfg.full_mv)
        begin
            level = blm_pkg::LVL_FULL;
        end
        else if (avg_reg >= cfg.mid_mv)
        begin
            level = blm_pkg::LVL_GOOD;
        end
        else if (avg_reg >= cfg.low_mv)
        begin
            level = blm_pkg::LVL_LOW;
        end
        else
        begin
            level = blm_pkg::LVL_EMPTY;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        div_req    = '0;
        case (state_reg)
            blm_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = blm_pkg::ST_AVG;
                end
            end
            blm_pkg::ST_AVG:
            begin
                // sum sits at the top of the dividend so only SUM_W steps are needed
                div_req.start    = 1'b1;
                div_req.steps    = blm_pkg::STEP_W'(blm_pkg::SUM_W);
                div_req.dividend = blm_pkg::DIV_W'(sum_reg)
                                   << (blm_pkg::DIV_W - blm_pkg::SUM_W);
                div_req.divisor  = blm_pkg::DIVISOR_W'(fill_reg);
                state_next       = blm_pkg::ST_AVG_WAIT;
            end
            blm_pkg::ST_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = blm_pkg::ST_PCT;
                end
            end
            blm_pkg::ST_PCT:
            begin
                if (pct_direct)
                begin
                    state_next = blm_pkg::ST_FINISH;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.steps    = blm_pkg::STEP_W'(blm_pkg::PCT_NUM_W);
                    div_req.dividend = blm_pkg::DIV_W'(
                        blm_pkg::PCT_NUM_W'(pct_delta) * blm_pkg::PCT_NUM_W'(blm_pkg::PCT_FULL));
                    div_req.divisor  = cfg.full_mv - cfg.empty_mv;
                    state_next       = blm_pkg::ST_PCT_WAIT;
                end
            end
            blm_pkg::ST_PCT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = blm_pkg::ST_FINISH;
                end
            end
            blm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = blm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            for (int i = 0; i < blm_pkg::AVG_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                sum_reg            <= sum_reg - blm_pkg::SUM_W'(ring_reg[slot_reg])
                                      + blm_pkg::SUM_W'(q_word.mv);
                ring_reg[slot_reg] <= q_word.mv;
                if (slot_reg == blm_pkg::SLOT_W'(blm_pkg::AVG_DEPTH - 1))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
                if (fill_reg != blm_pkg::CNT_W'(blm_pkg::AVG_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            chg_reg <= q_word.charging;
        end
        if ((state_reg == blm_pkg::ST_AVG_WAIT) && div_rsp.done)
        begin
            avg_reg <= div_rsp.quotient[blm_pkg::MV_W-1:0];
        end
        if (state_reg == blm_pkg::ST_PCT)
        begin
            pct_reg <= pct_direct_val;
        end
        else if ((state_reg == blm_pkg::ST_PCT_WAIT) && div_rsp.done)
        begin
            pct_reg <= div_rsp.quotient[blm_pkg::PCT_W-1:0];
        end
        if (load_out)
        begin
            out_word_reg.avg_mv        <= avg_reg;
            out_word_reg.level_state   <= level;
            out_word_reg.percent       <= pct_reg;
            out_word_reg.fully_charged <= !chg_reg && (avg_reg >= cfg.charged_mv);
        end
    end

endmodule

// File: sv/battery_level_monitor.sv
// Top level of the battery level monitor: register file and front/queue/back.
//
// Input channel (in_valid / in_stall / in_word): one word per battery sample,
// carrying the 12-bit ADC code and the charger status. A word is taken at a
// clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall / out_word): one word per input word,
// with the running average in mV, the level state, the percentage and the
// fully-charged flag. out_valid comes straight from the output register.
// The front scales the sample (one 12x20 multiply) and hands it to a
// two-entry queue; the back updates the ring and running sum, then runs the
// shared serial divider twice: average (SUM_W = 19 steps) and percent
// (23 steps, skipped when the result is clamped).
// The back works on one word at a time, through both divisions in turn, while
// the front and queue go on accepting new words.
// If the receiver stalls, the result waits in the output register while the
// back finishes the next word and the front/queue keep accepting up to three
// more; in_stall rises once those are full.
// Reset clears ring, running sum, fill count, slot pointer, queue and all
// valid flags, and loads the default thresholds and scale factor.
// Registers (APB, byte address 4*i): scale_q16, full_mv, mid_mv, low_mv,
// empty_mv, charged_mv. Write them only while the block is idle.
module battery_level_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  blm_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output blm_pkg::out_word_t            out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [blm_pkg::PADDR_W-1:0]   paddr,
    input  logic [blm_pkg::PDATA_W-1:0]   pwdata,
    output logic [blm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    blm_pkg::cfg_t     cfg_reg;
    logic              cfg_write;
    logic [2:0]        reg_index;

    logic              push;
    blm_pkg::q_word_t  push_word;
    logic              pop;
    blm_pkg::q_word_t  pop_word;
    logic              q_empty;
    logic              q_full;
    blm_pkg::div_req_t div_req;
    blm_pkg::div_rsp_t div_rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[blm_pkg::PADDR_W-1:2];

    // register file; writes to unused addresses are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_q16  <= blm_pkg::SCALE_RST;
            cfg_reg.full_mv    <= blm_pkg::FULL_RST;
            cfg_reg.mid_mv     <= blm_pkg::MID_RST;
            cfg_reg.low_mv     <= blm_pkg::LOW_RST;
            cfg_reg.empty_mv   <= blm_pkg::EMPTY_RST;
            cfg_reg.charged_mv <= blm_pkg::CHARGED_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                blm_pkg::REG_SCALE:   cfg_reg.scale_q16  <= pwdata[blm_pkg::SCALE_W-1:0];
                blm_pkg::REG_FULL:    cfg_reg.full_mv    <= pwdata[blm_pkg::MV_W-1:0];
                blm_pkg::REG_MID:     cfg_reg.mid_mv     <= pwdata[blm_pkg::MV_W-1:0];
                blm_pkg::REG_LOW:     cfg_reg.low_mv     <= pwdata[blm_pkg::MV_W-1:0];
                blm_pkg::REG_EMPTY:   cfg_reg.empty_mv   <= pwdata[blm_pkg::MV_W-1:0];
                blm_pkg::REG_CHARGED: cfg_reg.charged_mv <= pwdata[blm_pkg::MV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            blm_pkg::REG_SCALE:   prdata = blm_pkg::PDATA_W'(cfg_reg.scale_q16);
            blm_pkg::REG_FULL:    prdata = blm_pkg::PDATA_W'(cfg_reg.full_mv);
            blm_pkg::REG_MID:     prdata = blm_pkg::PDATA_W'(cfg_reg.mid_mv);
            blm_pkg::REG_LOW:     prdata = blm_pkg::PDATA_W'(cfg_reg.low_mv);
            blm_pkg::REG_EMPTY:   prdata = blm_pkg::PDATA_W'(cfg_reg.empty_mv);
            blm_pkg::REG_CHARGED: prdata = blm_pkg::PDATA_W'(cfg_reg.charged_mv);
            default:              prdata = '0;
        endcase
    end

    blm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .scale_q16 (cfg_reg.scale_q16),
        .push      (push),
        .push_word (push_word),
        .q_full    (q_full)
    );

    blm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .empty     (q_empty),
        .full      (q_full)
    );

    blm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    blm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_word    (pop_word),
        .pop       (pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
